// ===== rtl/gcr_pkg.sv =====
// Shared types and constants for the graph cycle and reachability engine.
// No dependencies; imported by every module of the block.
package gcr_pkg;

  localparam int NODES_DEF = 64;
  localparam int NODE_W    = 6;
  localparam int FUNC_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REACH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CYCLE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic ready;
    logic valid;
    logic answer;
  } status_t;

endpackage

// ===== rtl/gcr_first_free.sv =====
// Lowest set bit of (row & ~excl): isolate with one wide add, then encode.
// Depends on gcr_pkg.
module gcr_first_free import gcr_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic [NODES-1:0]         row_i,
  input  logic [NODES-1:0]         excl_i,
  output logic                     found_o,
  output logic [$clog2(NODES)-1:0] index_o
);

  localparam int IDX_W = $clog2(NODES);

  logic [NODES-1:0] cand;
  logic [NODES-1:0] iso;

  assign cand    = row_i & ~excl_i;
  assign iso     = cand & (~cand + NODES'(1));
  assign found_o = |cand;

  always_comb begin
    index_o = '0;
    for (int k = 0; k < IDX_W; k++) begin
      for (int i = 0; i < NODES; i++) begin
        if (i[k]) begin
          index_o[k] = index_o[k] | iso[i];
        end
      end
    end
  end

endmodule

// ===== rtl/gcr_dfs_core.sv =====
// Search sequencer: adjacency memory, explicit stack, visit and path marks.
// Depends on gcr_pkg and gcr_first_free.
module gcr_dfs_core import gcr_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  req_t    req_i,
  input  logic    rsp_ack_i,
  output status_t status_o
);

  localparam int IDX_W = $clog2(NODES);
  localparam int DEP_W = $clog2(NODES + 1);
  localparam logic [NODES-1:0] ONE = NODES'(1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_WR, S_EVAL, S_LOAD, S_CSCAN, S_CCHK, S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [IDX_W-1:0]    a_q, a_d;
  logic [IDX_W-1:0]    b_q, b_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [IDX_W-1:0]    s_q, s_d;
  logic [DEP_W-1:0]    depth_q, depth_d;
  logic [NODES-1:0]    visited_q, visited_d;
  logic [NODES-1:0]    onpath_q, onpath_d;
  logic                ans_q, ans_d;

  logic [NODES-1:0]    adj_mem [NODES];
  logic [NODES-1:0]    adj_rd_q;
  logic                adj_we;
  logic [IDX_W-1:0]    adj_addr;
  logic [NODES-1:0]    adj_wdata;

  logic [IDX_W-1:0]    stk_mem [NODES];
  logic [IDX_W-1:0]    stk_rd_q;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_addr;
  logic [IDX_W-1:0]    stk_wdata;

  logic                ff_found;
  logic [IDX_W-1:0]    ff_index;
  logic [IDX_W-1:0]    req_a;
  logic [IDX_W-1:0]    req_b;
  logic                a_ok;
  logic                b_ok;

  gcr_first_free #(.NODES(NODES)) u_ff (
    .row_i   (adj_rd_q),
    .excl_i  (visited_q),
    .found_o (ff_found),
    .index_o (ff_index)
  );

  assign req_a = IDX_W'(req_i.node_a);
  assign req_b = IDX_W'(req_i.node_b);
  assign a_ok  = int'(req_i.node_a) < NODES;
  assign b_ok  = int'(req_i.node_b) < NODES;

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    a_d       = a_q;
    b_d       = b_q;
    cur_d     = cur_q;
    s_d       = s_q;
    depth_d   = depth_q;
    visited_d = visited_q;
    onpath_d  = onpath_q;
    ans_d     = ans_q;
    adj_we    = 1'b0;
    adj_addr  = cur_q;
    adj_wdata = adj_rd_q | (ONE << b_q);
    stk_we    = 1'b0;
    stk_addr  = depth_q[IDX_W-1:0];
    stk_wdata = ff_index;

    case (state_q)
      S_CLR: begin
        adj_we    = 1'b1;
        adj_addr  = s_q;
        adj_wdata = '0;
        s_d       = s_q + IDX_W'(1);
        if (s_q == IDX_W'(NODES - 1)) begin
          s_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          func_d = req_i.func;
          a_d    = req_a;
          b_d    = req_b;
          case (req_i.func)
            FUNC_ADD: begin
              if (req_i.node_a != req_i.node_b && a_ok && b_ok) begin
                adj_addr = req_a;
                state_d  = S_ADD_WR;
              end else begin
                ans_d   = 1'b0;
                state_d = S_RESP;
              end
            end
            FUNC_REACH: begin
              if (req_i.node_a == req_i.node_b) begin
                ans_d   = 1'b1;
                state_d = S_RESP;
              end else if (!(a_ok && b_ok)) begin
                ans_d   = 1'b0;
                state_d = S_RESP;
              end else begin
                // clear marks and push the start vertex
                visited_d = ONE << req_a;
                onpath_d  = ONE << req_a;
                stk_we    = 1'b1;
                stk_addr  = '0;
                stk_wdata = req_a;
                depth_d   = DEP_W'(1);
                cur_d     = req_a;
                adj_addr  = req_a;
                state_d   = S_EVAL;
              end
            end
            FUNC_CYCLE: begin
              visited_d = '0;
              onpath_d  = '0;
              depth_d   = '0;
              s_d       = '0;
              state_d   = S_CSCAN;
            end
            default: begin
              ans_d   = 1'b0;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ADD_WR: begin
        adj_we    = 1'b1;
        adj_addr  = a_q;
        ans_d     = 1'b1;
        state_d   = S_RESP;
      end
      S_CSCAN: begin
        adj_addr = s_q;
        state_d  = S_CCHK;
      end
      S_CCHK: begin
        // keep row s in the read register for the first evaluation
        adj_addr = s_q;
        if ((|adj_rd_q) && !visited_q[s_q]) begin
          visited_d[s_q] = 1'b1;
          onpath_d[s_q]  = 1'b1;
          stk_we         = 1'b1;
          stk_addr       = '0;
          stk_wdata      = s_q;
          depth_d        = DEP_W'(1);
          cur_d          = s_q;
          state_d        = S_EVAL;
        end else if (s_q == IDX_W'(NODES - 1)) begin
          ans_d   = 1'b0;
          state_d = S_RESP;
        end else begin
          s_d     = s_q + IDX_W'(1);
          state_d = S_CSCAN;
        end
      end
      S_EVAL: begin
        if (func_q == FUNC_REACH && cur_q == b_q) begin
          ans_d   = 1'b1;
          state_d = S_RESP;
        end else if (func_q == FUNC_CYCLE && (|(adj_rd_q & onpath_q))) begin
          // back edge to a vertex on the current path
          ans_d   = 1'b1;
          state_d = S_RESP;
        end else if (ff_found) begin
          visited_d[ff_index] = 1'b1;
          onpath_d[ff_index]  = 1'b1;
          stk_we              = 1'b1;
          depth_d             = depth_q + DEP_W'(1);
          cur_d               = ff_index;
          adj_addr            = ff_index;
        end else begin
          onpath_d[cur_q] = 1'b0;
          depth_d         = depth_q - DEP_W'(1);
          if (depth_q == DEP_W'(1)) begin
            if (func_q == FUNC_CYCLE && s_q != IDX_W'(NODES - 1)) begin
              s_d     = s_q + IDX_W'(1);
              state_d = S_CSCAN;
            end else begin
              ans_d   = 1'b0;
              state_d = S_RESP;
            end
          end else begin
            // fetch the new top of stack
            stk_addr = IDX_W'(depth_q - DEP_W'(2));
            state_d  = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cur_d    = stk_rd_q;
        adj_addr = stk_rd_q;
        state_d  = S_EVAL;
      end
      S_RESP: begin
        if (rsp_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      func_q    <= FUNC_ADD;
      a_q       <= '0;
      b_q       <= '0;
      cur_q     <= '0;
      s_q       <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      onpath_q  <= '0;
      ans_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      func_q    <= func_d;
      a_q       <= a_d;
      b_q       <= b_d;
      cur_q     <= cur_d;
      s_q       <= s_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      onpath_q  <= onpath_d;
      ans_q     <= ans_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_addr] <= adj_wdata;
    end
    adj_rd_q <= adj_mem[adj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_addr];
  end

  assign status_o.ready  = (state_q == S_IDLE);
  assign status_o.valid  = (state_q == S_RESP);
  assign status_o.answer = ans_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEP_W'(NODES))
    else $error("stack depth beyond vertex count");

  a_path_in_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (onpath_q & ~visited_q) == '0)
    else $error("path mark on unvisited vertex");

  a_top_on_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> onpath_q[cur_q] && depth_q != '0)
    else $error("evaluated vertex not on path");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && stk_we |=> depth_q == $past(depth_q) + DEP_W'(1))
    else $error("push did not grow the stack");

endmodule

// ===== rtl/graph_cycle_and_reach_engine.sv =====
// Top level of the graph cycle and reachability engine: handshakes and result register.
// Depends on gcr_pkg and gcr_dfs_core.
//
//   channel  direction  signals                              accepted when
//   in       to block   in_valid_i, in_stall_o, func_i,      in_valid_i && !in_stall_o
//                       node_a_i, node_b_i
//   out      from block out_valid_o, out_stall_i, answer_o   out_valid_o && !out_stall_i
//
// After reset the adjacency memory is cleared one row a cycle; no requests are taken meanwhile.
// A valid add edge reads and rewrites one row. Search time of reachability and cycle queries
// is set by the single-port adjacency memory (one row read per step) and the stack read on
// each pop.
// One request is in work at a time; a result waits in the output register while the next
// request is taken; the search holds in its result state while a full register is stalled.
module graph_cycle_and_reach_engine import gcr_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              answer_o
);

  req_t    req;
  status_t status;
  logic    start;
  logic    rsp_ack;
  logic    out_valid_q, out_valid_d;
  logic    answer_q, answer_d;

  assign req.func   = func_i;
  assign req.node_a = node_a_i;
  assign req.node_b = node_b_i;

  assign in_stall_o = !status.ready;
  assign start      = in_valid_i && status.ready;
  // load the result when the output register is empty or being drained
  assign rsp_ack    = status.valid && (!out_valid_q || !out_stall_i);

  gcr_dfs_core #(.NODES(NODES)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req),
    .rsp_ack_i (rsp_ack),
    .status_o  (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    answer_d    = answer_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (rsp_ack) begin
      out_valid_d = 1'b1;
      answer_d    = status.answer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      answer_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      answer_q    <= answer_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule
